[hdl/sfd_pkg.sv]
// ----------------------------------------------------------------------------
// SBUS frame decoder package
// Shared widths, constants, register indexes and types for the decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

   // Field widths of the byte and result channels.
   localparam int BYTE_WIDTH    = 8;
   localparam int CHAN_WIDTH    = 11;
   localparam int INDEX_WIDTH   = 5;
   localparam int STAT_WIDTH    = 16;

   // Frame layout: 24 stored bytes, the 25th closes the frame.
   localparam int STORE_DEPTH   = 24;
   localparam int NUM_PROP      = 16;
   localparam int NUM_CHAN      = 18;
   localparam int FLAG_BYTE     = 23;
   localparam int STREAM_WIDTH  = NUM_PROP * CHAN_WIDTH;

   localparam logic [INDEX_WIDTH-1:0] LAST_POSITION = 5'd24;
   localparam logic [INDEX_WIDTH-1:0] LAST_CHANNEL  = 5'd17;
   localparam logic [CHAN_WIDTH-1:0]  DIGITAL_ON    = 11'h7FF;
   localparam logic [CHAN_WIDTH-1:0]  DIGITAL_OFF   = 11'h000;

   // Flag byte bit positions.
   localparam int FLAG_DIGITAL_0 = 0;
   localparam int FLAG_DIGITAL_1 = 1;
   localparam int FLAG_LOST      = 2;
   localparam int FLAG_FAILSAFE  = 3;

   // Configuration register map.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_BYTE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_BYTE   = 1'b1;

   localparam logic [BYTE_WIDTH-1:0] START_BYTE_RESET = 8'h0F;
   localparam logic [BYTE_WIDTH-1:0] END_BYTE_RESET   = 8'h00;

   typedef logic [BYTE_WIDTH-1:0]      byte_type;
   typedef logic [CHAN_WIDTH-1:0]      chan_type;
   typedef logic [INDEX_WIDTH-1:0]     index_type;
   typedef logic [STAT_WIDTH-1:0]      stat_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

endpackage

[hdl/sfd_if.sv]
// ----------------------------------------------------------------------------
// SBUS frame decoder channel interfaces
// Valid/ready channels for received bytes and decoded channel results.
// ----------------------------------------------------------------------------

// Received byte channel.
interface sfd_req_if;
   import sfd_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// Decoded channel result channel.
interface sfd_rsp_if;
   import sfd_pkg::*;

   logic      valid;
   logic      ready;
   index_type channel_index;
   chan_type  channel_value;
   logic      failsafe;
   logic      frame_lost;
   stat_type  good_frames;
   stat_type  bad_frames;
   stat_type  lost_frames;
   logic      last;

   modport source (output valid, output channel_index, output channel_value,
                   output failsafe, output frame_lost, output good_frames,
                   output bad_frames, output lost_frames, output last,
                   input ready);
   modport sink   (input valid, input channel_index, input channel_value,
                   input failsafe, input frame_lost, input good_frames,
                   input bad_frames, input lost_frames, input last,
                   output ready);
endinterface

[hdl/sbus_frame_decoder_core.sv]
// ----------------------------------------------------------------------------
// SBUS frame decoder core
// Assembles 25-byte SBUS frames and emits eighteen decoded channel results.
// ----------------------------------------------------------------------------
// Usage:
// Bytes enter on the req channel, one transaction per byte, and one byte can
// be taken in every cycle while req ready is high. A frame opens with the
// start byte; the start byte and the following 23 bytes are stored in a
// shift register, and the 25th byte must equal the end byte. A good frame
// is decoded in the cycle its end byte is accepted:
// sixteen 11-bit channels, two digital channels and the flags are captured in
// a result buffer, together with a snapshot of the frame counters.
// The rsp channel then presents channels 0 to 17, one transaction per cycle
// while rsp ready is high, starting the cycle after the end byte; last marks channel 17.
// The buffer holds one frame, so the 18 results drain while the next frame's
// bytes arrive. If the receiver stalls long enough that a new frame's 25th
// byte arrives before the previous results are all taken, req ready drops
// on that byte until the final result goes out.
// The csr port writes start_byte (index 0) and end_byte (index 1); write
// only while the block is idle.
// Reset clears the frame position, the counters and the result buffer state,
// and restores start_byte to 0x0F and end_byte to 0x00.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   sfd_req_if.sink                req_if,
   sfd_rsp_if.source              rsp_if,
   input  logic                   csr_we,
   input  sfd_pkg::csr_index_type csr_index,
   input  sfd_pkg::byte_type      csr_wdata
);
   import sfd_pkg::*;

   // Configuration registers.
   byte_type start_byte_ff, start_byte_in;
   byte_type end_byte_ff, end_byte_in;

   // Frame assembly state.
   index_type        position_ff, position_in;
   byte_type         store_ff [STORE_DEPTH];
   byte_type         store_in [STORE_DEPTH];
   logic [COUNT_WIDTH-1:0] good_cnt_ff, good_cnt_in;
   logic [COUNT_WIDTH-1:0] bad_cnt_ff, bad_cnt_in;
   logic [COUNT_WIDTH-1:0] lost_cnt_ff, lost_cnt_in;

   // Result buffer.
   logic      busy_ff, busy_in;
   index_type out_idx_ff, out_idx_in;
   chan_type  chan_ff [NUM_PROP];
   chan_type  chan_in [NUM_PROP];
   logic [FLAG_FAILSAFE:0] flags_ff, flags_in;
   stat_type  good_snap_ff, good_snap_in;
   stat_type  bad_snap_ff, bad_snap_in;
   stat_type  lost_snap_ff, lost_snap_in;

   logic                    req_fire;
   logic                    rsp_fire;
   logic                    stray;
   logic                    at_end;
   logic                    frame_good;
   logic                    frame_bad_end;
   logic                    store_byte;
   logic [STREAM_WIDTH-1:0] stream;

   // Handshake decode.
   assign req_fire      = req_if.valid && req_if.ready;
   assign rsp_fire      = rsp_if.valid && rsp_if.ready;
   assign at_end        = (position_ff == LAST_POSITION);
   assign stray         = (position_ff == '0) && (req_if.rx_byte != start_byte_ff);
   assign store_byte    = req_fire && !stray && !at_end;
   assign frame_good    = req_fire && at_end && (req_if.rx_byte == end_byte_ff);
   assign frame_bad_end = req_fire && at_end && (req_if.rx_byte != end_byte_ff);

   // A closing byte waits while the result buffer still holds a frame.
   assign req_if.ready = !(at_end && busy_ff);

   // Bit stream of payload bytes 1..22, little-endian.
   always_comb begin
      for (int j = 0; j < NUM_PROP * CHAN_WIDTH / BYTE_WIDTH; j++) begin
         stream[j*BYTE_WIDTH +: BYTE_WIDTH] = store_ff[j+1];
      end
   end

   // Configuration writes.
   always_comb begin
      start_byte_in = start_byte_ff;
      end_byte_in   = end_byte_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_START_BYTE: start_byte_in = csr_wdata;
            CSR_END_BYTE:   end_byte_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // Frame position, byte shift register and counters.
   always_comb begin
      position_in = position_ff;
      good_cnt_in = good_cnt_ff;
      bad_cnt_in  = bad_cnt_ff;
      lost_cnt_in = lost_cnt_ff;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         store_in[i] = store_ff[i];
      end
      if (store_byte) begin
         position_in = position_ff + 1'b1;
         for (int i = 0; i < STORE_DEPTH - 1; i++) begin
            store_in[i] = store_ff[i+1];
         end
         store_in[STORE_DEPTH-1] = req_if.rx_byte;
      end
      if (req_fire && at_end) begin
         position_in = '0;
      end
      if (req_fire && (stray || frame_bad_end)) begin
         bad_cnt_in = bad_cnt_ff + 1'b1;
      end
      if (frame_good) begin
         good_cnt_in = good_cnt_ff + 1'b1;
         if (store_ff[FLAG_BYTE][FLAG_LOST]) begin
            lost_cnt_in = lost_cnt_ff + 1'b1;
         end
      end
   end

   // Result buffer load on a good frame and drain on the rsp side.
   always_comb begin
      busy_in      = busy_ff;
      out_idx_in   = out_idx_ff;
      flags_in     = flags_ff;
      good_snap_in = good_snap_ff;
      bad_snap_in  = bad_snap_ff;
      lost_snap_in = lost_snap_ff;
      for (int k = 0; k < NUM_PROP; k++) begin
         chan_in[k] = chan_ff[k];
      end
      if (rsp_fire) begin
         out_idx_in = out_idx_ff + 1'b1;
         if (out_idx_ff == LAST_CHANNEL) begin
            busy_in = 1'b0;
         end
      end
      if (frame_good) begin
         busy_in      = 1'b1;
         out_idx_in   = '0;
         flags_in     = store_ff[FLAG_BYTE][FLAG_FAILSAFE:0];
         good_snap_in = STAT_WIDTH'(good_cnt_in);
         bad_snap_in  = STAT_WIDTH'(bad_cnt_ff);
         lost_snap_in = STAT_WIDTH'(lost_cnt_in);
         for (int k = 0; k < NUM_PROP; k++) begin
            chan_in[k] = stream[k*CHAN_WIDTH +: CHAN_WIDTH];
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RESET;
         end_byte_ff   <= END_BYTE_RESET;
         position_ff   <= '0;
         good_cnt_ff   <= '0;
         bad_cnt_ff    <= '0;
         lost_cnt_ff   <= '0;
         busy_ff       <= 1'b0;
         out_idx_ff    <= '0;
      end else begin
         start_byte_ff <= start_byte_in;
         end_byte_ff   <= end_byte_in;
         position_ff   <= position_in;
         good_cnt_ff   <= good_cnt_in;
         bad_cnt_ff    <= bad_cnt_in;
         lost_cnt_ff   <= lost_cnt_in;
         busy_ff       <= busy_in;
         out_idx_ff    <= out_idx_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         store_ff[i] <= store_in[i];
      end
      for (int k = 0; k < NUM_PROP; k++) begin
         chan_ff[k] <= chan_in[k];
      end
      flags_ff     <= flags_in;
      good_snap_ff <= good_snap_in;
      bad_snap_ff  <= bad_snap_in;
      lost_snap_ff <= lost_snap_in;
   end

   // Result selection from the buffer.
   always_comb begin
      if (out_idx_ff < INDEX_WIDTH'(NUM_PROP)) begin
         rsp_if.channel_value = chan_ff[out_idx_ff[3:0]];
      end else if (out_idx_ff[0] ? flags_ff[FLAG_DIGITAL_1] : flags_ff[FLAG_DIGITAL_0]) begin
         rsp_if.channel_value = DIGITAL_ON;
      end else begin
         rsp_if.channel_value = DIGITAL_OFF;
      end
   end

   assign rsp_if.valid         = busy_ff;
   assign rsp_if.channel_index = out_idx_ff;
   assign rsp_if.failsafe      = flags_ff[FLAG_FAILSAFE];
   assign rsp_if.frame_lost    = flags_ff[FLAG_LOST];
   assign rsp_if.good_frames   = good_snap_ff;
   assign rsp_if.bad_frames    = bad_snap_ff;
   assign rsp_if.lost_frames   = lost_snap_ff;
   assign rsp_if.last          = (out_idx_ff == LAST_CHANNEL);

   // The frame position never passes the closing byte.
   a_position_range: assert property (@(posedge clock) disable iff (reset)
      position_ff <= LAST_POSITION)
      else $error("frame position out of range");

   // While a frame drains, the result index stays within the channel list.
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (out_idx_ff <= LAST_CHANNEL))
      else $error("result index out of range");

   // Taking the final result empties the buffer.
   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_if.last) |=> !rsp_if.valid)
      else $error("result buffer still busy after last result");

   // A good frame loads the buffer with channel 0 and advances the count.
   a_frame_load: assert property (@(posedge clock) disable iff (reset)
      frame_good |=> (busy_ff && (out_idx_ff == '0)
                      && (good_cnt_ff == $past(good_cnt_ff) + 1'b1)))
      else $error("good frame not loaded into result buffer");

endmodule
